/* hw/rtl/rcn_pkg.sv */
// ----------------------------------------------------------------------------
// rcn_pkg
// Shared types and constants of the RC channel normalizer: command codes,
// calibration limits and reset values, and the structs passed between the
// calibration table, the link monitor and the top level.
// ----------------------------------------------------------------------------
package rcn_pkg;

    // field widths
    localparam int CH_W     = 5;   // channel index
    localparam int PW_W     = 12;  // pulse width in microseconds
    localparam int DZI_W    = 10;  // dead zone as written
    localparam int DZ_W     = 7;   // dead zone as stored (0..100)
    localparam int SPAN_W   = 11;  // max - min, at most 1400
    localparam int RSSI_W   = 8;
    localparam int CNT_W    = 6;   // channels per frame, 0..32
    localparam int TMO_W    = 16;  // signal loss timeout
    localparam int ELAPSED_W = 17;
    localparam int PROD_W   = 21;  // dead zone products
    localparam int VALUE_W  = 16;  // normalized output

    // parameter defaults
    localparam int CHANNELS_DEF      = 18;
    localparam int FRACTION_BITS_DEF = 14;

    // calibration limits
    localparam logic [PW_W-1:0]  CAL_MIN_LO = PW_W'(800);
    localparam logic [PW_W-1:0]  CAL_MIN_HI = PW_W'(1500);
    localparam logic [PW_W-1:0]  CAL_MAX_LO = PW_W'(1500);
    localparam logic [PW_W-1:0]  CAL_MAX_HI = PW_W'(2200);
    localparam logic [DZI_W-1:0] CAL_DZ_HI  = DZI_W'(100);
    localparam logic [PROD_W-1:0] DZ_SCALE  = PROD_W'(1000);

    // reset values
    localparam logic [PW_W-1:0]      MIN_RST     = PW_W'(1000);
    localparam logic [PW_W-1:0]      MAX_RST     = PW_W'(2000);
    localparam logic [DZ_W-1:0]      DZ_RST      = DZ_W'(5);
    localparam logic [TMO_W-1:0]     TIMEOUT_RST = TMO_W'(1000);
    localparam logic [RSSI_W-1:0]    RSSI_RST    = RSSI_W'(255);
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_CAL    = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [PW_W-1:0] min_pw;
        logic [PW_W-1:0] max_pw;
        logic [DZ_W-1:0] deadzone;
        logic            reverse;
    } cal_entry_t;

    typedef struct packed {
        logic              frame;   // last sample of a frame
        logic              tick;    // millisecond tick
        logic [RSSI_W-1:0] rssi;
        logic              avail;
        logic [CH_W-1:0]   ch;
    } frame_req_t;

    typedef struct packed {
        logic              link_ok;
        logic [RSSI_W-1:0] rssi;
        logic [CNT_W-1:0]  count;
    } link_status_t;

endpackage

/* hw/rtl/rcn_cal_table.sv */
// ----------------------------------------------------------------------------
// rcn_cal_table
// Per-channel calibration entries with clamping on write and a registered
// read port.
// ----------------------------------------------------------------------------
module rcn_cal_table #(
    parameter int CHANNELS = rcn_pkg::CHANNELS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [rcn_pkg::CH_W-1:0]     wr_ch,
    input  logic [rcn_pkg::PW_W-1:0]     wr_min,
    input  logic [rcn_pkg::PW_W-1:0]     wr_max,
    input  logic [rcn_pkg::DZI_W-1:0]    wr_deadzone,
    input  logic                         wr_reverse,
    input  logic                         rd_en,
    input  logic [rcn_pkg::CH_W-1:0]     rd_ch,
    output rcn_pkg::cal_entry_t          rd_entry
);
    import rcn_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    cal_entry_t table_reg [CHANNELS];
    cal_entry_t rd_entry_reg;
    cal_entry_t wr_entry;
    logic       wr_ok;

    assign wr_ok = ({1'b0, wr_ch} < (CH_W + 1)'(CHANNELS));

    always_comb begin
        priority if (wr_min < CAL_MIN_LO) begin
            wr_entry.min_pw = CAL_MIN_LO;
        end else if (wr_min > CAL_MIN_HI) begin
            wr_entry.min_pw = CAL_MIN_HI;
        end else begin
            wr_entry.min_pw = wr_min;
        end
        priority if (wr_max < CAL_MAX_LO) begin
            wr_entry.max_pw = CAL_MAX_LO;
        end else if (wr_max > CAL_MAX_HI) begin
            wr_entry.max_pw = CAL_MAX_HI;
        end else begin
            wr_entry.max_pw = wr_max;
        end
        if (wr_deadzone > CAL_DZ_HI) begin
            wr_entry.deadzone = CAL_DZ_HI[DZ_W-1:0];
        end else begin
            wr_entry.deadzone = wr_deadzone[DZ_W-1:0];
        end
        wr_entry.reverse = wr_reverse;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                table_reg[i] <= '{min_pw: MIN_RST, max_pw: MAX_RST,
                                  deadzone: DZ_RST, reverse: 1'b0};
            end
        end else if (wr_en && wr_ok) begin
            table_reg[wr_ch[IDX_W-1:0]] <= wr_entry;
        end
    end

    // out-of-range reads are never used downstream
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_entry_reg <= table_reg[rd_ch[IDX_W-1:0]];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

/* hw/rtl/rcn_link_mon.sv */
// ----------------------------------------------------------------------------
// rcn_link_mon
// Link supervision: records frame status on the last sample of a frame and
// counts millisecond ticks against the signal loss timeout.
// ----------------------------------------------------------------------------
module rcn_link_mon #(
    parameter int CHANNELS = rcn_pkg::CHANNELS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [rcn_pkg::TMO_W-1:0]  cfg_wdata,
    input  rcn_pkg::frame_req_t        req,
    output rcn_pkg::link_status_t      status
);
    import rcn_pkg::*;

    logic [TMO_W-1:0]     timeout_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic                 link_reg;
    logic [RSSI_W-1:0]    rssi_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_new;

    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg
                                                      : elapsed_reg + 1'b1;
    assign count_new = (CNT_W'(req.ch) + 1'b1 > CNT_W'(CHANNELS)) ? CNT_W'(CHANNELS)
                                                                 : CNT_W'(req.ch) + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RST;
            elapsed_reg <= '0;
            link_reg    <= 1'b0;
            rssi_reg    <= RSSI_RST;
            count_reg   <= '0;
        end else begin
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
            if (req.frame) begin
                rssi_reg    <= req.rssi;
                count_reg   <= count_new;
                link_reg    <= req.avail;
                elapsed_reg <= '0;
            end else if (req.tick) begin
                elapsed_reg <= elapsed_inc;
                // drop the link once the count passes the timeout
                if (elapsed_inc > ELAPSED_W'(timeout_reg)) begin
                    link_reg <= 1'b0;
                end
            end
        end
    end

    assign status = '{link_ok: link_reg, rssi: rssi_reg, count: count_reg};

endmodule

/* hw/rtl/rcn_divider.sv */
// ----------------------------------------------------------------------------
// rcn_divider
// Restoring divider, one quotient bit per cycle. The numerator's low QW bits
// shift out of a register as the quotient bits shift in.
// ----------------------------------------------------------------------------
module rcn_divider #(
    parameter int QW = rcn_pkg::FRACTION_BITS_DEF + 2,
    parameter int DW = rcn_pkg::SPAN_W + 1,
    localparam int NW = DW + QW
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] numer,
    input  logic [DW-1:0] denom,
    output logic          done,
    output logic [QW-1:0] quot
);
    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] rem_reg;
    logic [QW-1:0] shift_reg;
    logic [DW-1:0] denom_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, shift_reg[QW-1]};
    assign fits  = (trial >= {1'b0, denom_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(QW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // top part of the numerator is below the divisor, so QW steps suffice
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= numer[NW-1:QW];
            shift_reg <= numer[QW-1:0];
            denom_reg <= denom;
        end else if (busy_reg) begin
            rem_reg   <= fits ? DW'(trial - {1'b0, denom_reg}) : trial[DW-1:0];
            shift_reg <= {shift_reg[QW-2:0], fits};
        end
    end

    assign done = busy_reg && (cnt_reg == CW'(1));
    assign quot = shift_reg;

endmodule

/* hw/rtl/rc_channel_normalizer.sv */
// ----------------------------------------------------------------------------
// rc_channel_normalizer
// Calibrates RC channel pulse widths to a signed Q1.FRACTION_BITS value,
// applies dead zone and reverse, and supervises the radio link.
// ----------------------------------------------------------------------------
// One request is in flight at a time. A channel sample passes the span, load
// and divide states, waiting in the divide state until the restoring divider,
// which yields one quotient bit per cycle, is done; a zero-span sample skips
// the divider, and a sample beyond the table, ticks and calibration writes go
// straight to the done state. The result register lets the next request
// enter while a result still waits. Command rides on s_tuser, last_channel on
// s_tlast, value_valid on m_tuser. The user writes the timeout register through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
// Calibration entries are written in band with the calibration command.
// ----------------------------------------------------------------------------
module rc_channel_normalizer #(
    parameter int CHANNELS      = rcn_pkg::CHANNELS_DEF,
    parameter int FRACTION_BITS = rcn_pkg::FRACTION_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [rcn_pkg::TMO_W-1:0]  cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // channel_index, raw_value, rssi, signal_available, cal_min, cal_max,
    // cal_deadzone, cal_reverse, zero fill
    input  logic [63:0]                s_tdata,
    input  logic [1:0]                 s_tuser,   // command
    input  logic                       s_tlast,   // last_channel
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // out_channel, value, in_dead_zone, link_ok, rssi_out, channel_count,
    // zero fill
    output logic [39:0]                m_tdata,
    output logic                       m_tuser    // value_valid
);
    import rcn_pkg::*;

    localparam int QW = FRACTION_BITS + 2;
    localparam int DW = SPAN_W + 1;
    localparam int NW = DW + QW;
    localparam logic [QW-1:0] HALF = QW'(1) << FRACTION_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPAN,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [PW_W-1:0]   raw_reg;
    logic              ch_ok_reg;
    logic [SPAN_W-1:0] span_reg;
    logic [SPAN_W-1:0] d_reg;
    logic              zero_reg;
    logic              one_reg;
    logic [PROD_W-1:0] prod_d_reg;
    logic [PROD_W-1:0] prod_s_reg;
    logic              m_tvalid_reg;
    logic              m_tuser_reg;
    logic [39:0]       m_tdata_reg;

    // unpacked input fields
    cmd_t               in_cmd;
    logic [CH_W-1:0]    in_ch;
    logic [PW_W-1:0]    in_raw;
    logic [RSSI_W-1:0]  in_rssi;
    logic               in_avail;
    logic [PW_W-1:0]    in_cmin;
    logic [PW_W-1:0]    in_cmax;
    logic [DZI_W-1:0]   in_cdz;
    logic               in_crev;

    logic               accept;
    logic               out_load;
    cal_entry_t         cal;
    frame_req_t         freq;
    link_status_t       link;

    logic [SPAN_W-1:0]  span_c;
    logic [PW_W:0]      diff_c;
    logic [SPAN_W-1:0]  dclamp_c;
    logic [SPAN_W-1:0]  d_c;
    logic               one_c;

    logic               div_start;
    logic               div_done;
    logic [NW-1:0]      div_numer;
    logic [QW-1:0]      div_quot;

    logic                    res_valid;
    logic                    res_dz;
    logic signed [QW-1:0]    res_q;
    logic [VALUE_W-1:0]      res_val;

    assign in_cmd   = cmd_t'(s_tuser);
    assign in_ch    = s_tdata[4:0];
    assign in_raw   = s_tdata[16:5];
    assign in_rssi  = s_tdata[24:17];
    assign in_avail = s_tdata[25];
    assign in_cmin  = s_tdata[37:26];
    assign in_cmax  = s_tdata[49:38];
    assign in_cdz   = s_tdata[59:50];
    assign in_crev  = s_tdata[60];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    assign freq = '{frame: accept && (in_cmd == CMD_SAMPLE) && s_tlast,
                    tick:  accept && (in_cmd == CMD_TICK),
                    rssi:  in_rssi, avail: in_avail, ch: in_ch};

    rcn_cal_table #(
        .CHANNELS (CHANNELS)
    ) u_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (accept && (in_cmd == CMD_CAL)),
        .wr_ch       (in_ch),
        .wr_min      (in_cmin),
        .wr_max      (in_cmax),
        .wr_deadzone (in_cdz),
        .wr_reverse  (in_crev),
        .rd_en       (accept),
        .rd_ch       (in_ch),
        .rd_entry    (cal)
    );

    rcn_link_mon #(
        .CHANNELS (CHANNELS)
    ) u_link (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (freq),
        .status    (link)
    );

    // span and clamped, reversed distance from min
    always_comb begin
        span_c = SPAN_W'(cal.max_pw - cal.min_pw);
        diff_c = {1'b0, raw_reg} - {1'b0, cal.min_pw};
        priority if (diff_c[PW_W]) begin
            dclamp_c = '0;
        end else if (diff_c[PW_W-1:0] > PW_W'(span_c)) begin
            dclamp_c = span_c;
        end else begin
            dclamp_c = diff_c[SPAN_W-1:0];
        end
        d_c   = cal.reverse ? span_c - dclamp_c : dclamp_c;
        one_c = (raw_reg > cal.min_pw) ^ cal.reverse;
    end

    // quotient of (d * 2^(F+2) + span) / (2 * span)
    assign div_numer = (NW'(d_reg) << QW) + NW'(span_reg);
    assign div_start = (state_reg == ST_LOAD) && !zero_reg;

    rcn_divider #(
        .QW (QW),
        .DW (DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .denom   ({span_reg, 1'b0}),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        res_valid = (cmd_reg == CMD_SAMPLE) && ch_ok_reg;
        res_q     = signed'(div_quot - HALF);
        res_dz    = 1'b0;
        res_val   = '0;
        if (res_valid) begin
            if (zero_reg) begin
                res_dz  = !one_reg;
                res_val = one_reg ? VALUE_W'(signed'(HALF)) : '0;
            end else begin
                res_dz  = (prod_d_reg <= prod_s_reg);
                res_val = res_dz ? '0 : VALUE_W'(res_q);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cmd_reg   <= in_cmd;
                        ch_reg    <= in_ch;
                        raw_reg   <= in_raw;
                        ch_ok_reg <= ({1'b0, in_ch} < (CH_W + 1)'(CHANNELS));
                        if ((in_cmd == CMD_SAMPLE) &&
                            ({1'b0, in_ch} < (CH_W + 1)'(CHANNELS))) begin
                            state_reg <= ST_SPAN;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_SPAN: begin
                    span_reg  <= span_c;
                    d_reg     <= d_c;
                    zero_reg  <= (span_c == '0);
                    one_reg   <= one_c;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    prod_d_reg <= PROD_W'(d_reg) * DZ_SCALE;
                    prod_s_reg <= PROD_W'(cal.deadzone) * PROD_W'(span_reg);
                    state_reg  <= zero_reg ? ST_DONE : ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_valid;
                        m_tdata_reg  <= {3'b000, link.count, link.rssi, link.link_ok,
                                         res_dz, res_val, ch_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_no_div_on_zero_span: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !zero_reg)
        else $error("divider started on a zero span");

    a_done_only_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("request accepted while another is in flight");

    a_valid_only_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res_valid) |-> (cmd_reg == CMD_SAMPLE))
        else $error("value marked valid for a non-sample request");

    a_deadzone_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[21]) |-> (m_tdata[20:5] == '0))
        else $error("dead zone result with nonzero value");
`endif

endmodule
